@@ rtl/core/array_list_engine_core_assert.svh @@
// ---------------------------------------------------------------------------
// array list engine assertion macros
// concurrent checks clocked on clk, with and without the reset guard
// ---------------------------------------------------------------------------
`ifndef ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_CORE_ASSERT_SVH

// check that holds outside reset
`define ALE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("array list engine check failed");

// check that holds at every edge, reset included
`define ALE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("array list engine check failed");

`endif

@@ rtl/core/ale_pkg.sv @@
// ---------------------------------------------------------------------------
// ale_pkg
// shared types and constants of the array list engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ale_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_APPEND    = 3'd1,
    CMD_SET       = 3'd2,
    CMD_GET       = 3'd3,
    CMD_REMOVE    = 3'd4,
    CMD_FIND      = 3'd5,
    CMD_REMOVE_EQ = 3'd6,
    CMD_CLEAR     = 3'd7
  } ale_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } ale_status_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic commit;
  } ale_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic walk_needed;
    logic walk_last;
    logic out_free;
  } ale_stat_t;

endpackage

@@ rtl/core/ale_cmd_if.sv @@
// ---------------------------------------------------------------------------
// ale_cmd_if
// command channel: valid/ready with command, position and data word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ale_cmd_if
  import ale_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] data_word;

  modport source (output valid, cmd, position, data_word, input ready);
  modport sink   (input valid, cmd, position, data_word, output ready);
endinterface

@@ rtl/core/ale_rsp_if.sv @@
// ---------------------------------------------------------------------------
// ale_rsp_if
// result channel: valid/ready with status, read word, position and length
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ale_rsp_if
  import ale_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   read_word;
  logic [FOUND_W-1:0]  found_position;
  logic [COUNT_W-1:0]  count_after;

  modport source (output valid, status, read_word, found_position, count_after, input ready);
  modport sink   (input valid, status, read_word, found_position, count_after, output ready);
endinterface

@@ rtl/core/array_list_engine_core.sv @@
// ---------------------------------------------------------------------------
// array_list_engine_core
// ordered list of up to DEPTH words with insert, remove, search and compaction
// ---------------------------------------------------------------------------
// usage:
//   req carries one command item (cmd, position, data_word); rsp returns one
//   result item per command (status, read_word, found_position, count_after).
//   one command is in flight at a time; req.ready is high while the sequencer
//   is idle, including while an earlier result still waits in the rsp register.
// sequence: after the accepting edge a command passes the check state; get,
//   insert, remove, find and remove-all then walk their N entries (N from 1
//   up to DEPTH), one per cycle through the single read port of the entry
//   store, and drain the read pipe; set, clear, refused commands and commands
//   with nothing to walk go from the check straight to the finish state,
//   where the result is committed into the rsp register
// reset: synchronous, clears the entry count and the result valid flag; stored
//   words are not cleared, only entries below the count are ever read
// stall: a held rsp keeps its result; the next command may run through its
//   walk and then waits in the finish state until the rsp register is free
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "array_list_engine_core_assert.svh"

module array_list_engine_core
  import ale_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  ale_cmd_if.sink   req,
  ale_rsp_if.source rsp
);

  ale_ctrl_t ctrl;
  ale_stat_t stat;

  ale_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  ale_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .cmd       (req.cmd),
    .position  (req.position),
    .data_word (req.data_word),
    .rsp       (rsp)
  );

  `ALE_ASSERT(a_one_in_flight, (req.valid && req.ready) |=> !req.ready)
  `ALE_ASSERT(a_commit_shows, ctrl.commit |=> rsp.valid)
  `ALE_ASSERT(a_walk_stops, (ctrl.step && stat.walk_last) |=> !ctrl.step)

endmodule

@@ rtl/core/ale_ctrl.sv @@
// ---------------------------------------------------------------------------
// ale_ctrl
// sequencer: accept, range check, entry walk, drain, commit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ale_ctrl
  import ale_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  ale_stat_t stat,
  output ale_ctrl_t ctrl
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_WALK   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready   = (state == S_IDLE);
  assign ctrl.load   = req_ready && req_valid;
  assign ctrl.check  = (state == S_CHECK);
  assign ctrl.step   = (state == S_WALK);
  assign ctrl.commit = (state == S_FINISH) && stat.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = stat.walk_needed ? S_WALK : S_FINISH;
      end
      S_WALK: begin
        if (stat.walk_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        // last read data lands here
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/ale_datapath.sv @@
// ---------------------------------------------------------------------------
// ale_datapath
// entry store, count, walk pointer, read pipe and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ale_datapath
  import ale_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ale_ctrl_t         ctrl,
  output ale_stat_t         stat,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [POS_W-1:0]  position,
  input  logic [DATA_W-1:0] data_word,
  ale_rsp_if.source         rsp
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // item and walk state
  ale_cmd_t             cmd_r;
  logic [POS_W-1:0]     pos_r;
  logic [WORD_BITS-1:0] word_r;
  logic [CNT_W-1:0]     count;
  logic [ADDR_W-1:0]    idx;
  logic [ADDR_W-1:0]    last_idx;
  logic                 dir_up;
  logic [ADDR_W-1:0]    ins_addr;
  ale_status_t          status_r;
  logic [WORD_BITS-1:0] read_r;
  logic [ADDR_W-1:0]    found_r;
  logic                 found_flag;
  logic [CNT_W-1:0]     kept;

  // store and read pipe
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata;
  logic                 pipe_vld;
  logic [ADDR_W-1:0]    pipe_idx;

  // result register
  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [DATA_W-1:0]   rsp_word;
  logic [FOUND_W-1:0]  rsp_found;
  logic [COUNT_W-1:0]  rsp_count;

  logic [63:0]          word_ext;
  logic [WORD_BITS-1:0] word_in;
  logic [CMP_W-1:0]     pos_e;
  logic [CMP_W-1:0]     cnt_e;
  logic [CMP_W-1:0]     ins_p;
  logic [CNT_W-1:0]     cnt_dec;
  logic [ADDR_W-1:0]    pos_a;
  logic                 full;

  ale_status_t       chk_status;
  logic              walk_needed;
  logic [ADDR_W-1:0] first_c;
  logic [ADDR_W-1:0] last_c;
  logic              dir_up_c;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [CNT_W-1:0]     count_next;

  logic [63:0] read_ext;
  logic [15:0] found_ext;
  logic [15:0] count_ext;

  assign word_ext = 64'(data_word);
  assign word_in  = word_ext[WORD_BITS-1:0];

  assign pos_e   = CMP_W'(pos_r);
  assign cnt_e   = CMP_W'(count);
  assign pos_a   = pos_e[ADDR_W-1:0];
  assign cnt_dec = count - CNT_W'(1);
  assign full    = (count == CNT_W'(DEPTH));
  assign ins_p   = (cmd_r == CMD_APPEND) ? cnt_e : pos_e;

  // range and capacity checks, walk bounds
  always_comb begin
    chk_status  = ST_OK;
    walk_needed = 1'b0;
    first_c     = '0;
    last_c      = cnt_dec[ADDR_W-1:0];
    dir_up_c    = 1'b1;
    unique case (cmd_r) inside
      CMD_INSERT, CMD_APPEND: begin
        if (ins_p > cnt_e) begin
          chk_status = ST_RANGE;
        end else if (full) begin
          chk_status = ST_FULL;
        end else if (ins_p < cnt_e) begin
          // shift up from the top entry down to the insert point
          walk_needed = 1'b1;
          first_c     = cnt_dec[ADDR_W-1:0];
          last_c      = ins_p[ADDR_W-1:0];
          dir_up_c    = 1'b0;
        end
      end
      CMD_SET: begin
        if (pos_e >= cnt_e) chk_status = ST_RANGE;
      end
      CMD_GET: begin
        if (pos_e >= cnt_e) begin
          chk_status = ST_RANGE;
        end else begin
          walk_needed = 1'b1;
          first_c     = pos_a;
          last_c      = pos_a;
        end
      end
      CMD_REMOVE: begin
        if (pos_e >= cnt_e) begin
          chk_status = ST_RANGE;
        end else begin
          walk_needed = 1'b1;
          first_c     = pos_a;
        end
      end
      CMD_FIND: begin
        chk_status  = ST_NOT_FOUND;
        walk_needed = (count != '0);
      end
      CMD_REMOVE_EQ: begin
        walk_needed = (count != '0);
      end
      CMD_CLEAR: begin
        walk_needed = 1'b0;
      end
      default: begin
        walk_needed = 1'b0;
      end
    endcase
  end

  assign stat.walk_needed = walk_needed;
  assign stat.walk_last   = (idx == last_idx);
  assign stat.out_free    = !rsp_valid || rsp.ready;

  // store write port: data moved during the walk, or the final write
  always_comb begin
    we    = 1'b0;
    waddr = pipe_idx;
    wdata = rdata;
    if (pipe_vld) begin
      unique case (cmd_r) inside
        CMD_INSERT, CMD_APPEND: begin
          we    = 1'b1;
          waddr = pipe_idx + ADDR_W'(1);
        end
        CMD_REMOVE: begin
          we    = (pipe_idx != pos_a);
          waddr = pipe_idx - ADDR_W'(1);
        end
        CMD_REMOVE_EQ: begin
          we    = (rdata != word_r);
          waddr = kept[ADDR_W-1:0];
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end else if (ctrl.commit && status_r == ST_OK) begin
      unique case (cmd_r) inside
        CMD_INSERT, CMD_APPEND: begin
          we    = 1'b1;
          waddr = ins_addr;
          wdata = word_r;
        end
        CMD_SET: begin
          we    = 1'b1;
          waddr = pos_a;
          wdata = word_r;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    count_next = count;
    unique case (cmd_r) inside
      CMD_INSERT, CMD_APPEND: begin
        if (status_r == ST_OK) count_next = count + CNT_W'(1);
      end
      CMD_REMOVE: begin
        if (status_r == ST_OK) count_next = cnt_dec;
      end
      CMD_REMOVE_EQ: begin
        count_next = kept;
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (ctrl.step) rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= 1'b0;
    end else begin
      pipe_vld <= ctrl.step;
    end
    pipe_idx <= idx;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r      <= ale_cmd_t'(cmd);
      pos_r      <= position;
      word_r     <= word_in;
      read_r     <= '0;
      found_r    <= '0;
      found_flag <= 1'b0;
    end
    if (ctrl.check) begin
      status_r <= chk_status;
      idx      <= first_c;
      last_idx <= last_c;
      dir_up   <= dir_up_c;
      ins_addr <= ins_p[ADDR_W-1:0];
      kept     <= '0;
    end
    if (ctrl.step) begin
      idx <= dir_up ? idx + ADDR_W'(1) : idx - ADDR_W'(1);
    end
    if (pipe_vld) begin
      unique case (cmd_r) inside
        CMD_GET: begin
          read_r <= rdata;
        end
        CMD_REMOVE: begin
          if (pipe_idx == pos_a) read_r <= rdata;
        end
        CMD_FIND: begin
          // keep only the first match
          if (rdata == word_r && !found_flag) begin
            found_flag <= 1'b1;
            found_r    <= pipe_idx;
            status_r   <= ST_OK;
          end
        end
        CMD_REMOVE_EQ: begin
          if (rdata != word_r) kept <= kept + CNT_W'(1);
        end
        default: begin
          kept <= kept;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.commit) begin
      count <= count_next;
    end
  end

  assign read_ext  = 64'(read_r);
  assign found_ext = 16'(found_r);
  assign count_ext = 16'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (ctrl.commit) begin
      rsp_status <= status_r;
      rsp_word   <= read_ext[DATA_W-1:0];
      rsp_found  <= found_ext[FOUND_W-1:0];
      rsp_count  <= count_ext[COUNT_W-1:0];
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.read_word      = rsp_word;
  assign rsp.found_position = rsp_found;
  assign rsp.count_after    = rsp_count;

endmodule
